/* src/sas_pkg.sv */
// sas_pkg: shared constants and types for the sprite alpha splat block
// no dependencies; used by the interfaces and all modules but sas_ram
`timescale 1ns / 1ps

package sas_pkg;

  // fixed field widths
  localparam int ChanW   = 16;
  localparam int PosW    = 11;
  localparam int SprIdxW = 8;
  localparam int AlphaW  = 9;
  localparam int TypeW   = 2;
  localparam int ColourN = 3;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int HeightW  = 9;
  localparam int WidthW   = 9;
  localparam int RadiusW  = 3;

  // holds any image dimension up to the largest supported size
  localparam int DimW = 11;

  localparam logic [AlphaW-1:0] AlphaOne = 9'd256;

  // defaults for the top level parameters
  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefMaxRadius = 7;
  localparam int DefChannels  = 3;

  localparam logic [HeightW-1:0] HeightReset = 9'd256;
  localparam logic [WidthW-1:0]  WidthReset  = 9'd256;
  localparam logic [RadiusW-1:0] RadiusReset = 3'd0;

  typedef enum logic [TypeW-1:0] {
    ReqLoadSprite = 2'd0,
    ReqWritePixel = 2'd1,
    ReqSplat      = 2'd2,
    ReqReadPixel  = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageHeight  = 2'd0,
    CfgImageWidth   = 2'd1,
    CfgSpriteRadius = 2'd2,
    CfgUnused       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWalk  = 3'b010,
    StDrain = 3'b100
  } state_e;

endpackage

/* src/sas_if.sv */
// sas_if: request, response and configuration channels of the splat block
// depends on sas_pkg for field widths
`timescale 1ns / 1ps

interface sas_req_if;
  logic                                valid;
  logic                                ready;
  logic [sas_pkg::TypeW-1:0]           req_type;
  logic signed [sas_pkg::PosW-1:0]     pos_x;
  logic signed [sas_pkg::PosW-1:0]     pos_y;
  logic [sas_pkg::SprIdxW-1:0]         sprite_index;
  logic [sas_pkg::ChanW-1:0]           value_0;
  logic [sas_pkg::ChanW-1:0]           value_1;
  logic [sas_pkg::ChanW-1:0]           value_2;

  modport source (
    output valid, req_type, pos_x, pos_y, sprite_index, value_0, value_1, value_2,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, sprite_index, value_0, value_1, value_2,
    output ready
  );
endinterface

interface sas_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [sas_pkg::ChanW-1:0] pixel_0;
  logic [sas_pkg::ChanW-1:0] pixel_1;
  logic [sas_pkg::ChanW-1:0] pixel_2;
  logic                      read_outside;

  modport source (
    output valid, pixel_0, pixel_1, pixel_2, read_outside,
    input  ready
  );
  modport sink (
    input  valid, pixel_0, pixel_1, pixel_2, read_outside,
    output ready
  );
endinterface

interface sas_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sas_pkg::CfgIdxW-1:0]  index;
  logic [sas_pkg::CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* src/sas_ram.sv */
// sas_ram: simple dual-port synchronous ram, one write and one registered read
// standalone; holds the image and the sprite opacities
`timescale 1ns / 1ps

module sas_ram #(
  parameter int Width = 16,
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sas_blend.sv */
// sas_blend: registered per-channel alpha blend, new = old + (a*(col-old))>>8
// depends on sas_pkg; feeds the image ram write port during a splat
`timescale 1ns / 1ps

module sas_blend #(
  parameter int CHANNELS = sas_pkg::DefChannels,
  parameter int AddrW    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [AddrW-1:0]                     addr_i,
  input  logic [CHANNELS*sas_pkg::ChanW-1:0]   old_i,
  input  logic [sas_pkg::AlphaW-1:0]           alpha_i,
  input  logic [sas_pkg::ColourN*sas_pkg::ChanW-1:0] colour_i,
  output logic                                 we_o,
  output logic [AddrW-1:0]                     addr_o,
  output logic [CHANNELS*sas_pkg::ChanW-1:0]   data_o
);

  localparam int ChanW = sas_pkg::ChanW;
  localparam int ProdW = ChanW + 1 + sas_pkg::AlphaW + 1;

  logic                    valid_q;
  logic [AddrW-1:0]        addr_q;
  logic [CHANNELS*ChanW-1:0] old_q;
  logic signed [ProdW-1:0] prod_d [CHANNELS];
  logic signed [ProdW-1:0] prod_q [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic [ChanW-1:0]        col;
    logic signed [ChanW:0]   diff;
    logic signed [ProdW-1:0] sum;

    // channels without a colour input blend toward zero
    if (c < sas_pkg::ColourN) begin : g_col
      assign col = colour_i[c*ChanW +: ChanW];
    end else begin : g_zero
      assign col = '0;
    end

    assign diff = $signed({1'b0, col}) - $signed({1'b0, old_i[c*ChanW +: ChanW]});

    always_comb begin
      prod_d[c] = ProdW'(diff) * ProdW'($signed({1'b0, alpha_i}));
    end

    // the 256*old term is exact, so floor of the whole sum is old plus floor
    assign sum = ProdW'($signed({1'b0, old_q[c*ChanW +: ChanW]})) + (prod_q[c] >>> 8);
    assign data_o[c*ChanW +: ChanW] = sum[ChanW-1:0];

    always_ff @(posedge clk_i) begin
      prod_q[c] <= prod_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    old_q  <= old_i;
  end

  assign we_o   = valid_q;
  assign addr_o = addr_q;

endmodule

/* src/sprite_alpha_splat_core.sv */
// sprite_alpha_splat_core: top level with request sequencer, window walker and rams
// depends on sas_pkg, sas_if, sas_ram and sas_blend
`timescale 1ns / 1ps

// Usage:
// req_i carries one beat per item: load a sprite opacity, write a pixel,
// splat a point, or read a pixel. rsp_o returns one beat per pixel read,
// no beat for the other kinds. cfg_i writes image height, image width and
// sprite radius; it is always ready and is meant to be used while idle.
// Throughput: sprite loads and pixel writes are accepted one per cycle while idle;
// a read waits while an earlier read is pending. A splat walks the (2r+1)*(2r+1)
// window one pixel per cycle; the image ram's single write port takes each blended
// pixel after the ram read and blend registers, and the pipeline then drains.
// A read beat reaches rsp_o through the ram read register and the output register.
// The response sits in an output register; while it waits the block still
// accepts loads, writes and splats, and holds off only the next read.
// Reset clears the sequencer, the pending response and the registers
// (height 256, width 256, radius 0); image and sprite rams are not cleared
// and must be written before they are read.
module sprite_alpha_splat_core #(
  parameter int MAX_WIDTH  = sas_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = sas_pkg::DefMaxHeight,
  parameter int MAX_RADIUS = sas_pkg::DefMaxRadius,
  parameter int CHANNELS   = sas_pkg::DefChannels
) (
  input  logic clk_i,
  input  logic rst_ni,
  sas_req_if.sink   req_i,
  sas_rsp_if.source rsp_o,
  sas_cfg_if.sink   cfg_i
);

  localparam int ChanW    = sas_pkg::ChanW;
  localparam int DimW     = sas_pkg::DimW;
  localparam int CoordW   = sas_pkg::PosW + 2;
  localparam int Pixels   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW    = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam int SprSide  = 2 * MAX_RADIUS + 1;
  localparam int SprDepth = SprSide * SprSide;
  localparam int SprAW    = (SprDepth > 1) ? $clog2(SprDepth) : 1;
  localparam int OffW     = $clog2(SprSide + 1);
  localparam int PixW     = CHANNELS * ChanW;

  // configuration
  logic [sas_pkg::HeightW-1:0] height_q;
  logic [sas_pkg::WidthW-1:0]  width_q;
  logic [sas_pkg::RadiusW-1:0] radius_q;
  logic [DimW-1:0]             eff_h;
  logic [DimW-1:0]             eff_w;
  logic [OffW-1:0]             eff_r;
  logic [OffW-1:0]             side;

  // sequencer and walker
  sas_pkg::state_e state_q, state_d;
  logic [OffW-1:0] ox_q, ox_d;
  logic [OffW-1:0] oy_q, oy_d;
  logic signed [sas_pkg::PosW-1:0] px_q, py_q;
  logic [sas_pkg::ColourN*ChanW-1:0] col_q;
  logic signed [CoordW-1:0] wx, wy;
  logic             walk_inside;
  logic [AddrW-1:0] walk_addr;
  logic [SprAW-1:0] walk_sidx;
  logic             walking;
  logic             s1_valid_q;
  logic [AddrW-1:0] s1_addr_q;

  // request side
  logic             acc;
  logic             is_read;
  logic             out_busy;
  logic signed [CoordW-1:0] rx, ry;
  logic             req_inside;
  logic [AddrW-1:0] req_addr;
  logic             req_img_we;
  logic [PixW-1:0]  req_wdata;
  logic             spr_we;
  logic [sas_pkg::AlphaW-1:0] spr_wdata;

  // rams and blend
  logic             img_we;
  logic [AddrW-1:0] img_waddr;
  logic [PixW-1:0]  img_wdata;
  logic [AddrW-1:0] img_raddr;
  logic [PixW-1:0]  img_rdata;
  logic [sas_pkg::AlphaW-1:0] spr_rdata;
  logic             blend_we;
  logic [AddrW-1:0] blend_addr;
  logic [PixW-1:0]  blend_data;

  // response
  logic             rd_pend_q;
  logic             rd_inside_q;
  logic             out_valid_q;
  logic [sas_pkg::ColourN*ChanW-1:0] out_pix_q, out_pix_d;
  logic             out_outside_q;

  function automatic logic in_image(input logic signed [CoordW-1:0] x,
                                    input logic signed [CoordW-1:0] y,
                                    input logic [DimW-1:0] w,
                                    input logic [DimW-1:0] h);
    logic ok;
    ok = !x[CoordW-1] && !y[CoordW-1] &&
         ($unsigned(x) < CoordW'(w)) && ($unsigned(y) < CoordW'(h));
    return ok;
  endfunction

  function automatic logic [AddrW-1:0] pix_addr(input logic signed [CoordW-1:0] x,
                                                input logic signed [CoordW-1:0] y);
    logic [AddrW-1:0] a;
    a = AddrW'(int'(y) * MAX_WIDTH + int'(x));
    return a;
  endfunction

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= sas_pkg::HeightReset;
      width_q  <= sas_pkg::WidthReset;
      radius_q <= sas_pkg::RadiusReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sas_pkg::CfgImageHeight:  height_q <= cfg_i.data[sas_pkg::HeightW-1:0];
        sas_pkg::CfgImageWidth:   width_q  <= cfg_i.data[sas_pkg::WidthW-1:0];
        sas_pkg::CfgSpriteRadius: radius_q <= cfg_i.data[sas_pkg::RadiusW-1:0];
        default: ;
      endcase
    end
  end

  // registers saturate at the built sizes
  assign eff_h = (int'(height_q) > MAX_HEIGHT) ? DimW'(MAX_HEIGHT) : DimW'(height_q);
  assign eff_w = (int'(width_q) > MAX_WIDTH) ? DimW'(MAX_WIDTH) : DimW'(width_q);
  assign eff_r = (int'(radius_q) > MAX_RADIUS) ? OffW'(MAX_RADIUS) : OffW'(radius_q);
  assign side  = OffW'({eff_r, 1'b1});

  // ---------------- request decode ----------------
  assign is_read  = (req_i.req_type == sas_pkg::ReqReadPixel);
  assign out_busy = rd_pend_q || (out_valid_q && !rsp_o.ready);
  assign req_i.ready = (state_q == sas_pkg::StIdle) && !(is_read && out_busy);
  assign acc = req_i.valid && req_i.ready;

  assign rx = CoordW'(req_i.pos_x);
  assign ry = CoordW'(req_i.pos_y);
  assign req_inside = in_image(rx, ry, eff_w, eff_h);
  assign req_addr   = pix_addr(rx, ry);
  assign req_img_we = acc && (req_i.req_type == sas_pkg::ReqWritePixel) && req_inside;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_wdata
    if (c == 0) begin : g_c0
      assign req_wdata[c*ChanW +: ChanW] = req_i.value_0;
    end else if (c == 1) begin : g_c1
      assign req_wdata[c*ChanW +: ChanW] = req_i.value_1;
    end else if (c == 2) begin : g_c2
      assign req_wdata[c*ChanW +: ChanW] = req_i.value_2;
    end else begin : g_cz
      assign req_wdata[c*ChanW +: ChanW] = '0;
    end
  end

  assign spr_we = acc && (req_i.req_type == sas_pkg::ReqLoadSprite) &&
                  (int'(req_i.sprite_index) < SprDepth);
  assign spr_wdata = (req_i.value_0 > ChanW'(sas_pkg::AlphaOne)) ?
                     sas_pkg::AlphaOne : req_i.value_0[sas_pkg::AlphaW-1:0];

  // ---------------- sequencer and window walker ----------------
  assign walking = (state_q == sas_pkg::StWalk);

  always_comb begin
    state_d = state_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    unique case (state_q)
      sas_pkg::StIdle: begin
        if (acc && (req_i.req_type == sas_pkg::ReqSplat)) begin
          state_d = sas_pkg::StWalk;
        end
      end
      sas_pkg::StWalk: begin
        if (ox_q == side - OffW'(1)) begin
          ox_d = '0;
          if (oy_q == side - OffW'(1)) begin
            oy_d    = '0;
            state_d = sas_pkg::StDrain;
          end else begin
            oy_d = oy_q + OffW'(1);
          end
        end else begin
          ox_d = ox_q + OffW'(1);
        end
      end
      sas_pkg::StDrain: begin
        // wait until the last blended pixel is written back
        if (!s1_valid_q && !blend_we) begin
          state_d = sas_pkg::StIdle;
        end
      end
      default: state_d = sas_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sas_pkg::StIdle;
      ox_q       <= '0;
      oy_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      s1_valid_q <= walking && walk_inside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && (req_i.req_type == sas_pkg::ReqSplat)) begin
      px_q  <= req_i.pos_x;
      py_q  <= req_i.pos_y;
      col_q <= {req_i.value_2, req_i.value_1, req_i.value_0};
    end
    s1_addr_q <= walk_addr;
  end

  assign wx = CoordW'(px_q) + CoordW'($signed({1'b0, ox_q})) -
              CoordW'($signed({1'b0, eff_r}));
  assign wy = CoordW'(py_q) + CoordW'($signed({1'b0, oy_q})) -
              CoordW'($signed({1'b0, eff_r}));
  assign walk_inside = in_image(wx, wy, eff_w, eff_h);
  assign walk_addr   = pix_addr(wx, wy);
  // sprite entries are stored column-major
  assign walk_sidx   = SprAW'(int'(oy_q) + int'(side) * int'(ox_q));

  // ---------------- rams and blend ----------------
  assign img_we    = req_img_we || blend_we;
  assign img_waddr = blend_we ? blend_addr : req_addr;
  assign img_wdata = blend_we ? blend_data : req_wdata;
  assign img_raddr = walking ? walk_addr : req_addr;

  sas_ram #(
    .Width (PixW),
    .Depth (Pixels),
    .AddrW (AddrW)
  ) u_image_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (img_wdata),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  sas_ram #(
    .Width (sas_pkg::AlphaW),
    .Depth (SprDepth),
    .AddrW (SprAW)
  ) u_sprite_ram (
    .clk_i   (clk_i),
    .we_i    (spr_we),
    .waddr_i (SprAW'(req_i.sprite_index)),
    .wdata_i (spr_wdata),
    .raddr_i (walk_sidx),
    .rdata_o (spr_rdata)
  );

  sas_blend #(
    .CHANNELS (CHANNELS),
    .AddrW    (AddrW)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .addr_i   (s1_addr_q),
    .old_i    (img_rdata),
    .alpha_i  (spr_rdata),
    .colour_i (col_q),
    .we_o     (blend_we),
    .addr_o   (blend_addr),
    .data_o   (blend_data)
  );

  // ---------------- response ----------------
  for (genvar c = 0; c < sas_pkg::ColourN; c++) begin : g_out
    if (c < CHANNELS) begin : g_have
      assign out_pix_d[c*ChanW +: ChanW] = rd_inside_q ? img_rdata[c*ChanW +: ChanW] : '0;
    end else begin : g_none
      assign out_pix_d[c*ChanW +: ChanW] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= acc && is_read;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_read) begin
      rd_inside_q <= req_inside;
    end
    if (rd_pend_q) begin
      out_pix_q     <= out_pix_d;
      out_outside_q <= !rd_inside_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.pixel_0      = out_pix_q[0*ChanW +: ChanW];
  assign rsp_o.pixel_1      = out_pix_q[1*ChanW +: ChanW];
  assign rsp_o.pixel_2      = out_pix_q[2*ChanW +: ChanW];
  assign rsp_o.read_outside = out_outside_q;

  // ---------------- assertions ----------------
  a_write_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(blend_we && req_img_we))
    else $error("image write port claimed by request and blend at once");

  a_accept_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> (!s1_valid_q && !blend_we))
    else $error("item accepted while a splat is still in flight");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q)
    else $error("pending read did not reach the output register");

  a_walk_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !walking |-> (ox_q == '0 && oy_q == '0))
    else $error("walk offsets not at zero outside a splat");

endmodule

/* tb/sprite_alpha_splat_checker.sv */
// sprite_alpha_splat_checker: watches the request, response and config channels,
// keeps its own image and opacity stores and compares every pixel read beat
// depends on sas_pkg and the channel interfaces in sas_if
`timescale 1ns / 1ps

module sprite_alpha_splat_checker
  import sas_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight,
  parameter int MAX_RADIUS = DefMaxRadius
) (
  input  logic clk_i,
  input  logic rst_ni,
  sas_req_if   req_mon,
  sas_rsp_if   rsp_mon,
  sas_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int PixelCount  = MAX_WIDTH * MAX_HEIGHT;
  localparam int SpriteSide  = 2 * MAX_RADIUS + 1;
  localparam int SpriteDepth = SpriteSide * SpriteSide;
  localparam int MaxReports  = 40;

  typedef struct packed {
    logic [ChanW-1:0] pixel_0;
    logic [ChanW-1:0] pixel_1;
    logic [ChanW-1:0] pixel_2;
    logic             read_outside;
  } pixel_rsp_t;

  logic [ColourN-1:0][ChanW-1:0] image_mem [PixelCount];
  logic [AlphaW-1:0]             opacity_mem [SpriteDepth];
  logic [HeightW-1:0]            height_q;
  logic [WidthW-1:0]             width_q;
  logic [RadiusW-1:0]            radius_q;
  pixel_rsp_t                    pixel_reads_due [$];
  int                            mismatches;

  task automatic report_mismatch(string field, logic [ChanW-1:0] got,
                                 logic [ChanW-1:0] want);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t ns pixel read %s: got %h, want %h", $time, field, got, want);
    end
  endtask

  // true when (x, y) lies inside the configured image, with its store address
  function automatic bit locate(int x, int y, output int addr);
    int eff_w;
    int eff_h;
    eff_h = (int'(height_q) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_q);
    eff_w = (int'(width_q) > MAX_WIDTH) ? MAX_WIDTH : int'(width_q);
    addr  = 0;
    if (x < 0 || y < 0 || x >= eff_w || y >= eff_h) begin
      return 1'b0;
    end
    addr = y * MAX_WIDTH + x;
    return addr < PixelCount;
  endfunction

  function automatic logic [ChanW-1:0] blend(logic [ChanW-1:0] old_val,
                                             logic [ChanW-1:0] colour_val,
                                             logic [AlphaW-1:0] alpha);
    int unsigned keep;
    int unsigned mix;
    keep = 32'(AlphaOne) - 32'(alpha);
    mix  = (keep * 32'(old_val) + 32'(alpha) * 32'(colour_val)) >> 8;
    return mix[ChanW-1:0];
  endfunction

  task automatic step_image_model();
    int                            x;
    int                            y;
    int                            addr;
    int                            r;
    int                            side;
    int                            sidx;
    int                            ox;
    int                            oy;
    int                            c;
    logic [AlphaW-1:0]             alpha;
    logic [ColourN-1:0][ChanW-1:0] colour;
    pixel_rsp_t                    want;
    x      = int'(req_mon.pos_x);
    y      = int'(req_mon.pos_y);
    colour = {req_mon.value_2, req_mon.value_1, req_mon.value_0};
    case (req_mon.req_type)
      ReqLoadSprite: begin
        if (int'(req_mon.sprite_index) < SpriteDepth) begin
          opacity_mem[req_mon.sprite_index] = (req_mon.value_0 > ChanW'(AlphaOne)) ?
                                              AlphaOne : req_mon.value_0[AlphaW-1:0];
        end
      end
      ReqWritePixel: begin
        if (locate(x, y, addr)) begin
          image_mem[addr] = colour;
        end
      end
      ReqSplat: begin
        r    = (int'(radius_q) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
        side = 2 * r + 1;
        for (oy = 0; oy < side; oy++) begin
          for (ox = 0; ox < side; ox++) begin
            // opacity entries run down the sprite column first
            sidx  = oy + side * ox;
            alpha = (sidx < SpriteDepth) ? opacity_mem[sidx] : '0;
            if (locate(x + ox - r, y + oy - r, addr)) begin
              for (c = 0; c < ColourN; c++) begin
                image_mem[addr][c] = blend(image_mem[addr][c], colour[c], alpha);
              end
            end
          end
        end
      end
      default: begin
        if (locate(x, y, addr)) begin
          want.pixel_0      = image_mem[addr][0];
          want.pixel_1      = image_mem[addr][1];
          want.pixel_2      = image_mem[addr][2];
          want.read_outside = 1'b0;
        end else begin
          want.pixel_0      = '0;
          want.pixel_1      = '0;
          want.pixel_2      = '0;
          want.read_outside = 1'b1;
        end
        pixel_reads_due.push_back(want);
      end
    endcase
  endtask

  task automatic check_pixel_beat();
    pixel_rsp_t want;
    if (pixel_reads_due.size() == 0) begin
      report_mismatch("beat with no read outstanding", rsp_mon.pixel_0, '0);
    end else begin
      want = pixel_reads_due.pop_front();
      if (rsp_mon.pixel_0 !== want.pixel_0) begin
        report_mismatch("pixel_0", rsp_mon.pixel_0, want.pixel_0);
      end
      if (rsp_mon.pixel_1 !== want.pixel_1) begin
        report_mismatch("pixel_1", rsp_mon.pixel_1, want.pixel_1);
      end
      if (rsp_mon.pixel_2 !== want.pixel_2) begin
        report_mismatch("pixel_2", rsp_mon.pixel_2, want.pixel_2);
      end
      if (rsp_mon.read_outside !== want.read_outside) begin
        report_mismatch("read_outside", ChanW'(rsp_mon.read_outside),
                        ChanW'(want.read_outside));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q = HeightReset;
      width_q  = WidthReset;
      radius_q = RadiusReset;
      pixel_reads_due.delete();
      mismatches = 0;
    end else begin
      // a response beat always belongs to an older read, so retire it first
      if (rsp_mon.valid && rsp_mon.ready) begin
        check_pixel_beat();
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CfgImageHeight:  height_q = cfg_mon.data[HeightW-1:0];
          CfgImageWidth:   width_q  = cfg_mon.data[WidthW-1:0];
          CfgSpriteRadius: radius_q = cfg_mon.data[RadiusW-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        step_image_model();
      end
    end
    pending_o    = pixel_reads_due.size();
    fail_count_o = mismatches;
  end

endmodule

/* tb/sprite_alpha_splat_core_tb.sv */
// sprite_alpha_splat_core_tb: clock, reset, request and config stimulus, response
// back-pressure and the final verdict; checking lives in sprite_alpha_splat_checker
// depends on sas_pkg, sas_if, sprite_alpha_splat_core and the checker
`timescale 1ns / 1ps

module sprite_alpha_splat_core_tb;
  import sas_pkg::*;

  localparam int MaxWidth    = DefMaxWidth;
  localparam int MaxHeight   = DefMaxHeight;
  localparam int MaxRadius   = DefMaxRadius;
  localparam int PixelCount  = MaxWidth * MaxHeight;
  localparam int SpriteDepth = (2 * MaxRadius + 1) * (2 * MaxRadius + 1);
  // largest splat walk plus pipeline drain, with some slack
  localparam int SplatDrain  = SpriteDepth + 4 + 16;
  localparam int LongHold    = 400;
  // request beats for the whole run, fill writes included
  localparam int ItemBudget  = 1500;
  localparam int PhaseCount  = 12;
  localparam int CycleLimit  = 5_000_000;

  localparam int PhaseH [8] = '{256, 1, 17, 256, 0, 256, 300, 100};
  localparam int PhaseW [8] = '{256, 1, 5, 256, 256, 0, 511, 37};
  localparam int PhaseR [8] = '{0, 7, 3, 7, 2, 5, 1, 6};

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   reads_pending;
  int   cycle_count;
  int   items_sent;
  bit   req_burst;
  bit   rsp_burst;
  bit   pixel_written [PixelCount];
  int   cur_h;
  int   cur_w;
  int   cur_r;

  sas_req_if req_if ();
  sas_rsp_if rsp_if ();
  sas_cfg_if cfg_if ();

  sprite_alpha_splat_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  sprite_alpha_splat_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (reads_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle gaps with occasional back-to-back stretches
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) begin
      burst = !burst;
    end
    return burst ? 0 : int'($urandom_range(0, 13));
  endfunction

  function automatic bit in_image(int x, int y);
    return x >= 0 && y >= 0 && x < cur_w && y < cur_h;
  endfunction

  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom);
    endcase
  endfunction

  function automatic logic [ChanW-1:0] rand_opacity();
    case ($urandom_range(0, 5))
      0:       return ChanW'(AlphaOne);
      1:       return ChanW'($urandom);
      default: return ChanW'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic int noise_pos();
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // coordinates cluster near the origin and near the far image edge
  function automatic int near_edge(int extent);
    if ($urandom_range(0, 2) != 0) begin
      return int'($urandom_range(0, 40)) - 8;
    end
    return extent - 32 + int'($urandom_range(0, 40));
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(req_type_e kind, int x, int y, int sidx,
                           logic [ChanW-1:0] v0, logic [ChanW-1:0] v1,
                           logic [ChanW-1:0] v2);
    int gap;
    gap = draw_gap(req_burst);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.pos_x        <= PosW'(x);
    req_if.pos_y        <= PosW'(y);
    req_if.sprite_index <= SprIdxW'(sidx);
    req_if.value_0      <= v0;
    req_if.value_1      <= v1;
    req_if.value_2      <= v2;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
    items_sent++;
    if (kind == ReqWritePixel && in_image(x, y)) begin
      pixel_written[y * MaxWidth + x] = 1'b1;
    end
  endtask

  // never let a splat or read touch a pixel that has not been written
  task automatic ensure_written(int x, int y);
    if (in_image(x, y) && !pixel_written[y * MaxWidth + x]) begin
      send_beat(ReqWritePixel, x, y, $urandom_range(0, 255), rand_chan(), rand_chan(),
                rand_chan());
    end
  endtask

  task automatic do_splat(int x, int y, logic [ChanW-1:0] v0, logic [ChanW-1:0] v1,
                          logic [ChanW-1:0] v2);
    int ox;
    int oy;
    for (oy = 0; oy <= 2 * cur_r; oy++) begin
      for (ox = 0; ox <= 2 * cur_r; ox++) begin
        ensure_written(x + ox - cur_r, y + oy - cur_r);
      end
    end
    send_beat(ReqSplat, x, y, $urandom_range(0, 255), v0, v1, v2);
  endtask

  task automatic do_read(int x, int y);
    ensure_written(x, y);
    send_beat(ReqReadPixel, x, y, $urandom_range(0, 255), rand_chan(), rand_chan(),
              rand_chan());
  endtask

  // drop valid, wait for all reads to return and for a splat walk to drain
  task automatic settle();
    req_if.valid <= 1'b0;
    while (reads_pending != 0) @(negedge clk_i);
    repeat (SplatDrain) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CfgDataW'(value);
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic set_config(int h, int w, int r);
    settle();
    write_reg(CfgUnused, $urandom_range(0, 511));
    write_reg(CfgImageHeight, h);
    write_reg(CfgImageWidth, w);
    write_reg(CfgSpriteRadius, r);
    cfg_if.valid <= 1'b0;
    cur_h = (h > MaxHeight) ? MaxHeight : h;
    cur_w = (w > MaxWidth) ? MaxWidth : w;
    cur_r = (r > MaxRadius) ? MaxRadius : r;
  endtask

  task automatic directed_items();
    send_beat(ReqWritePixel, 0, 0, 0, 16'hFFFF, 16'h0000, 16'h8000);
    do_read(0, 0);
    send_beat(ReqWritePixel, 255, 255, 0, 16'h0000, 16'hFFFF, 16'h1234);
    do_read(255, 255);
    do_read(-1, 0);
    do_read(0, 256);
    do_read(-1024, 1023);
    do_read(1023, -1024);
    // write past the last column is dropped
    send_beat(ReqWritePixel, 256, 3, 0, '1, '1, '1);
    do_read(256, 3);
    // opacity above one saturates, index past the store is dropped
    send_beat(ReqLoadSprite, 0, 0, 0, 16'hFFFF, 16'h0000, 16'h0000);
    send_beat(ReqLoadSprite, 0, 0, 255, 16'h0000, 16'h0000, 16'h0000);
    do_splat(0, 0, 16'h1111, 16'h2222, 16'h3333);
    do_read(0, 0);
    send_beat(ReqLoadSprite, 0, 0, 0, 16'd128, 16'h0000, 16'h0000);
    do_splat(0, 0, 16'hFFFF, 16'h0000, 16'hFFFF);
    do_read(0, 0);
    do_splat(-1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // zero height: nothing is inside
    set_config(0, 256, 0);
    send_beat(ReqWritePixel, 0, 0, 0, 16'h5555, 16'hAAAA, 16'h0F0F);
    do_read(0, 0);
    do_splat(0, 0, 16'h0000, 16'h0000, 16'h0000);
    // oversized dimensions saturate, widest window
    set_config(511, 300, 7);
    do_splat(0, 0, 16'hABCD, 16'h0001, 16'hFFFE);
    do_read(0, 0);
    do_read(7, 7);
    do_splat(255, 255, 16'hFFFF, 16'h8000, 16'h0000);
    do_read(255, 255);
  endtask

  task automatic random_item();
    int sel;
    int x;
    int y;
    sel = $urandom_range(0, 99);
    x   = near_edge(cur_w);
    y   = near_edge(cur_h);
    if (sel < 35) begin
      do_splat(x, y, rand_chan(), rand_chan(), rand_chan());
    end else if (sel < 60) begin
      do_read(x, y);
    end else if (sel < 80) begin
      send_beat(ReqWritePixel, x, y, $urandom_range(0, 255), rand_chan(), rand_chan(),
                rand_chan());
    end else if (sel < 90) begin
      send_beat(ReqLoadSprite, noise_pos(), noise_pos(), $urandom_range(0, 255),
                rand_opacity(), rand_chan(), rand_chan());
    end else begin
      x = noise_pos();
      y = noise_pos();
      case ($urandom_range(0, 3))
        0: send_beat(ReqLoadSprite, x, y, $urandom_range(0, 255), ChanW'($urandom),
                     rand_chan(), rand_chan());
        1: send_beat(ReqWritePixel, x, y, $urandom_range(0, 255), rand_chan(),
                     rand_chan(), rand_chan());
        2: do_splat(x, y, rand_chan(), rand_chan(), rand_chan());
        default: do_read(x, y);
      endcase
    end
  endtask

  initial begin : rsp_drain
    int gap;
    int beats_taken;
    beats_taken  = 0;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      // two long hold-offs let the block fill up and stall its input
      gap = (beats_taken == 20 || beats_taken == 80) ? LongHold : draw_gap(rsp_burst);
      if (gap != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      beats_taken++;
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run exceeded %0d cycles", CycleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int idx;
    int phase;
    int phase_end;
    rst_ni              = 1'b0;
    items_sent          = 0;
    req_if.valid        = 1'b0;
    req_if.req_type     = ReqLoadSprite;
    req_if.pos_x        = '0;
    req_if.pos_y        = '0;
    req_if.sprite_index = '0;
    req_if.value_0      = '0;
    req_if.value_1      = '0;
    req_if.value_2      = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CfgImageHeight;
    cfg_if.data         = '0;
    cur_h               = int'(HeightReset);
    cur_w               = int'(WidthReset);
    cur_r               = int'(RadiusReset);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // every opacity entry is loaded before the first splat
    for (idx = 0; idx < SpriteDepth; idx++) begin
      send_beat(ReqLoadSprite, noise_pos(), noise_pos(), idx, rand_opacity(), rand_chan(),
                rand_chan());
    end
    directed_items();
    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase < 8) begin
        set_config(PhaseH[phase], PhaseW[phase], PhaseR[phase]);
      end else begin
        set_config($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 7));
      end
      // spread what is left of the beat budget over the remaining phases
      phase_end = items_sent + (ItemBudget - items_sent) / (PhaseCount - phase);
      while (items_sent < phase_end) begin
        random_item();
      end
    end
    settle();
    if (fail_count == 0 && reads_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
